FILE: rtl/core/sha256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PADW,
        S_HREAD,
        S_ROUND,
        S_HUPD,
        S_OREAD,
        S_OSHOW
    } t_state;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_PAD,
        SRC_PADLEN,
        SRC_LEN
    } t_src;

    typedef struct packed {
        logic load;
        logic step;
        logic shift;
    } t_core_ctl;

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [5:0]  LEN_OFFSET = 6'd56;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sha_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sha_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/sha_core.sv
`timescale 1ns / 1ps
`default_nettype none
module sha_core (
    input  wire logic                  i_clk,
    input  wire sha256_pkg::t_core_ctl i_ctl,
    input  wire logic [31:0]           i_din,
    input  wire logic [31:0]           i_w_in,
    input  wire logic [5:0]            i_round,
    output logic      [31:0]           o_v0
);
    import sha256_pkg::*;

    logic [31:0] r_v [8];
    logic [31:0] r_s [16];
    logic [31:0] w, t1, t2;
    logic        sched;

    assign sched = (i_round[5:4] != 2'b00);
    assign w = sched ? (r_s[0] + sml_sig0(r_s[1]) + r_s[9] + sml_sig1(r_s[14])) : i_w_in;
    assign t1 = r_v[7] + ROUND_K[i_round] + big_sig1(r_v[4])
              + ((r_v[4] & (r_v[5] ^ r_v[6])) ^ r_v[6]) + w;
    assign t2 = big_sig0(r_v[0]) + (((r_v[0] ^ r_v[1]) & (r_v[0] ^ r_v[2])) ^ r_v[0]);
    assign o_v0 = r_v[0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load || i_ctl.shift) begin
            for (int i = 0; i < 7; i++) begin
                r_v[i] <= r_v[i+1];
            end
            r_v[7] <= i_din;
        end else if (i_ctl.step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (i_ctl.step) begin
            for (int i = 0; i < 15; i++) begin
                r_s[i] <= r_s[i+1];
            end
            r_s[15] <= w;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/sha256_byte_stream_digest_top.sv
// sha-256 over a byte stream
// input channel: i_valid/o_ready carry i_data_byte and i_last_byte, one byte a word
// output channel: o_valid/i_ready carry o_digest_word, o_word_index, o_last_word
// bytes are taken one per cycle while a 64-byte block fills; a full block then
// runs a chaining read (buffer word 0 is read alongside), rounds 0 to 63 in the
// single round unit, one at a time, and then a chaining update
// a last byte that leaves a partial word adds a pad write (S_PADW), then one or
// two compressions follow, two when the padding needs a second block; the first
// digest word comes after the last chaining update and a chaining read (S_OREAD)
// each of the eight digest words is read (S_OREAD), then shown (S_OSHOW) until taken
// while the receiver stalls the current digest word holds and no byte is taken
// after the eighth word the block starts a new message
// reset (synchronous, active low) clears position, bit count and the chaining
// valid bits, so the chaining memory reads as the initial hash; no clearing pass
// block buffer and chaining value live in two memories with registered reads
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_digest_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [31:0] o_digest_word,
    output logic      [2:0]  o_word_index,
    output logic             o_last_word
);
    import sha256_pkg::*;

    t_state      r_state, n_state;
    t_src        r_mode;
    logic        r_fin;
    logic [5:0]  r_pos;
    logic [63:0] r_bitcnt;
    logic [23:0] r_acc;
    logic [3:0]  r_cnt;
    logic [5:0]  r_round;
    logic [7:0]  r_hvalid;
    logic        r_rd_iv;
    logic [2:0]  r_rd_idx;

    logic        in_fire, out_fire;
    logic [5:0]  p_next;
    logic        buf_we;
    logic [3:0]  buf_waddr, buf_raddr;
    logic [31:0] buf_wdata, buf_q, pad_word, fetch_w;
    logic        h_we, h_re;
    logic [2:0]  h_waddr, h_raddr;
    logic [31:0] h_wdata, h_q, chain_q, v0;
    t_core_ctl   ctl;
    logic [3:0]  j;

    assign in_fire  = i_valid & o_ready;
    assign out_fire = o_valid & i_ready;
    assign p_next   = r_pos + 6'd1;
    assign chain_q  = r_rd_iv ? INIT_H[r_rd_idx] : h_q;
    assign j        = r_round[3:0];

    always_comb begin
        unique case (r_pos[1:0])
            2'b01:   pad_word = {r_acc[7:0], PAD_MARK, 16'd0};
            2'b10:   pad_word = {r_acc[15:0], PAD_MARK, 8'd0};
            2'b11:   pad_word = {r_acc, PAD_MARK};
            default: pad_word = PAD_WORD;
        endcase
    end

    always_comb begin
        fetch_w = 32'd0;
        unique case (r_mode)
            SRC_DATA: fetch_w = buf_q;
            SRC_LEN: begin
                if (j == 4'd14) fetch_w = r_bitcnt[63:32];
                else if (j == 4'd15) fetch_w = r_bitcnt[31:0];
            end
            default: begin
                if (r_mode == SRC_PADLEN && j == 4'd14) fetch_w = r_bitcnt[63:32];
                else if (r_mode == SRC_PADLEN && j == 4'd15) fetch_w = r_bitcnt[31:0];
                else if (j < r_pos[5:2]) fetch_w = buf_q;
                else if (j == r_pos[5:2]) begin
                    fetch_w = (r_pos[1:0] != 2'b00) ? buf_q : PAD_WORD;
                end
            end
        endcase
    end

    sha_ram #(.W(32), .D(16)) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_re    (1'b1),
        .i_raddr (buf_raddr),
        .o_rdata (buf_q)
    );

    sha_ram #(.W(32), .D(8)) u_chain (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_re    (h_re),
        .i_raddr (h_raddr),
        .o_rdata (h_q)
    );

    sha_core u_core (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_din   (chain_q),
        .i_w_in  (fetch_w),
        .i_round (r_round),
        .o_v0    (v0)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (p_next == 6'd0) n_state = S_HREAD;
                    else if (i_last_byte) begin
                        n_state = (p_next[1:0] != 2'b00) ? S_PADW : S_HREAD;
                    end
                end
            end
            S_PADW:  n_state = S_HREAD;
            S_HREAD: if (r_cnt == 4'd8) n_state = S_ROUND;
            S_ROUND: if (r_round == 6'd63) n_state = S_HUPD;
            S_HUPD: begin
                if (r_cnt == 4'd8) begin
                    priority if (r_mode == SRC_DATA && !r_fin) n_state = S_IDLE;
                    else if (r_mode == SRC_DATA || r_mode == SRC_PAD) n_state = S_HREAD;
                    else n_state = S_OREAD;
                end
            end
            S_OREAD: n_state = S_OSHOW;
            S_OSHOW: if (i_ready) n_state = (r_cnt[2:0] == 3'd7) ? S_IDLE : S_OREAD;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        o_valid   = 1'b0;
        buf_we    = 1'b0;
        buf_waddr = r_pos[5:2];
        buf_wdata = {r_acc, i_data_byte};
        buf_raddr = 4'd0;
        h_we      = 1'b0;
        h_waddr   = r_cnt[2:0] - 3'd1;
        h_wdata   = chain_q + v0;
        h_re      = 1'b0;
        h_raddr   = r_cnt[2:0];
        ctl       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                buf_we  = in_fire && (r_pos[1:0] == 2'b11);
            end
            S_PADW: begin
                buf_we    = 1'b1;
                buf_wdata = pad_word;
            end
            S_HREAD: begin
                h_re     = !r_cnt[3];
                ctl.load = (r_cnt != 4'd0);
            end
            S_ROUND: begin
                buf_raddr = r_round[3:0] + 4'd1;
                ctl.step  = 1'b1;
            end
            S_HUPD: begin
                h_re      = !r_cnt[3];
                h_we      = (r_cnt != 4'd0);
                ctl.shift = (r_cnt != 4'd0);
            end
            S_OREAD: h_re = 1'b1;
            S_OSHOW: o_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_digest_word = chain_q;
    assign o_word_index  = r_cnt[2:0];
    assign o_last_word   = (r_cnt[2:0] == 3'd7);

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_acc <= {r_acc[15:0], i_data_byte};
        end
        if (h_re) begin
            r_rd_iv  <= !r_hvalid[h_raddr];
            r_rd_idx <= h_raddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= SRC_DATA;
            r_fin    <= 1'b0;
            r_pos    <= 6'd0;
            r_bitcnt <= 64'd0;
            r_cnt    <= 4'd0;
            r_round  <= 6'd0;
            r_hvalid <= 8'd0;
        end else begin
            r_state <= n_state;
            if (h_we) begin
                r_hvalid[h_waddr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_pos    <= p_next;
                        r_bitcnt <= r_bitcnt + 64'd8;
                        r_fin    <= i_last_byte;
                        priority if (!i_last_byte || p_next == 6'd0) r_mode <= SRC_DATA;
                        else if (p_next >= LEN_OFFSET) r_mode <= SRC_PAD;
                        else r_mode <= SRC_PADLEN;
                    end
                end
                S_HREAD: r_cnt <= (r_cnt == 4'd8) ? 4'd0 : r_cnt + 4'd1;
                S_ROUND: r_round <= r_round + 6'd1;
                S_HUPD: begin
                    r_cnt <= (r_cnt == 4'd8) ? 4'd0 : r_cnt + 4'd1;
                    if (r_cnt == 4'd8) begin
                        if (r_mode == SRC_DATA && r_fin) r_mode <= SRC_PADLEN;
                        else if (r_mode == SRC_PAD) r_mode <= SRC_LEN;
                    end
                end
                S_OSHOW: begin
                    if (i_ready) begin
                        if (r_cnt[2:0] == 3'd7) begin
                            r_cnt    <= 4'd0;
                            r_pos    <= 6'd0;
                            r_bitcnt <= 64'd0;
                            r_fin    <= 1'b0;
                            r_mode   <= SRC_DATA;
                            r_hvalid <= 8'd0;
                        end else begin
                            r_cnt <= r_cnt + 4'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_word |-> o_word_index == 3'd7)
        else $error("last word not at index 7");

    a_new_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && o_last_word |=> r_pos == 6'd0 && r_bitcnt == 64'd0 && r_hvalid == 8'd0)
        else $error("message state not cleared after digest");

    a_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROUND && r_round == 6'd63 |=> r_state == S_HUPD && r_round == 6'd0)
        else $error("round count out of step");

    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("byte taken during digest output");
endmodule
`default_nettype wire

FILE: tb/sha256_digest_checker.sv
`timescale 1ns / 1ps
module sha256_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_digest_word,
    input  logic [2:0]  i_word_index,
    input  logic        i_last_word,
    output int          o_fail_count,
    output int          o_pending
);
    import sha256_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_entry_t;

    logic [31:0]   hash_state [8];
    logic [7:0]    msg_block [64];
    logic [5:0]    fill_pos;
    logic [63:0]   bit_len;
    digest_entry_t digest_queue [$];

    function automatic logic [31:0] rot(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_msg_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (rot(w[i-15], 7) ^ rot(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (rot(w[i-2], 17) ^ rot(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + ROUND_K[i] + (rot(v[4], 6) ^ rot(v[4], 11) ^ rot(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + w[i];
            t2 = (rot(v[0], 2) ^ rot(v[0], 13) ^ rot(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic start_msg();
        for (int i = 0; i < 8; i++) hash_state[i] = INIT_H[i];
        fill_pos = '0;
        bit_len = '0;
    endtask

    task automatic absorb_byte(logic [7:0] b, logic fin);
        digest_entry_t e;
        msg_block[fill_pos] = b;
        bit_len += 64'd8;
        fill_pos += 6'd1;
        if (fill_pos == 0) compress_msg_block();
        if (fin) begin
            msg_block[fill_pos] = PAD_MARK;
            for (int i = fill_pos + 1; i < 64; i++) msg_block[i] = 8'h00;
            if (fill_pos >= LEN_OFFSET) begin
                compress_msg_block();
                for (int i = 0; i < 56; i++) msg_block[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++) msg_block[63-i] = bit_len[8*i +: 8];
            compress_msg_block();
            for (int i = 0; i < 8; i++) begin
                e.word = hash_state[i];
                e.idx = 3'(i);
                e.last = (i == 7);
                digest_queue = {digest_queue, e};
            end
            start_msg();
        end
    endtask

    initial begin
        o_fail_count = 0;
        start_msg();
    end

    assign o_pending = digest_queue.size();

    always @(posedge i_clk) begin
        digest_entry_t e;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (digest_queue.size() == 0) begin
                    $error("digest word with none expected: %h", i_digest_word);
                    o_fail_count++;
                end else begin
                    e = digest_queue.pop_front();
                    if (i_digest_word !== e.word) begin
                        $error("digest_word expected %h actual %h", e.word, i_digest_word);
                        o_fail_count++;
                    end
                    if (i_word_index !== e.idx) begin
                        $error("word_index expected %0d actual %0d", e.idx, i_word_index);
                        o_fail_count++;
                    end
                    if (i_last_word !== e.last) begin
                        $error("last_word expected %0d actual %0d", e.last, i_last_word);
                        o_fail_count++;
                    end
                end
            end
            if (i_valid && i_ready_in) absorb_byte(i_data_byte, i_last_byte);
        end
    end
endmodule

FILE: tb/sha256_byte_stream_digest_top_test.sv
`timescale 1ns / 1ps
module sha256_byte_stream_digest_top_test;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          calm;
    bit          timed_out;

    sha256_byte_stream_digest_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_data_byte(data_byte), .i_last_byte(last_byte),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_digest_word(digest_word), .o_word_index(word_index), .o_last_word(last_word)
    );

    sha256_digest_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_ready_in(in_ready),
        .i_data_byte(data_byte), .i_last_byte(last_byte),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_digest_word(digest_word), .i_word_index(word_index), .i_last_word(last_word),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(negedge clk) begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 4000 && !timed_out) begin
            timed_out <= 1'b1;
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, logic fin);
        while (!calm && $urandom_range(99) < 38) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_message(int len, bit rand_data, logic [7:0] fillv);
        for (int i = 0; i < len; i++)
            send_byte(rand_data ? 8'($urandom) : fillv, i == len - 1);
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        out_ready = 1'b0;
        calm = 1'b0;
        idle_cycles = 0;
        timed_out = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed lengths around the padding boundaries
        send_message(1, 0, 8'h00);
        send_message(1, 0, 8'hff);
        send_message(3, 1, 8'h00);
        send_message(55, 0, 8'hff);
        send_message(56, 1, 8'h00);
        send_message(64, 0, 8'h00);

        calm = 1'b1;
        send_message(70, 1, 8'h00);
        calm = 1'b0;

        for (int m = 0; m < 3; m++)
            send_message($urandom_range(1, 20), 1, 8'h00);
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
